/* design/fc_pkg.sv */
package fc_pkg;

	localparam int unsigned POS_W = 17;
	localparam int unsigned LEN_W = 16;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [LEN_W-1:0] len_t;

	// reflected IEEE polynomial
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam pos_t POS_LEN_LO   = pos_t'(2);
	localparam pos_t POS_LEN_HI   = pos_t'(3);
	localparam pos_t POS_CRC_LO   = pos_t'(8);
	localparam pos_t POS_HDR_LAST = pos_t'(11);
	localparam pos_t HDR_BYTES    = pos_t'(12);

	localparam logic [1:0] STATUS_OK           = 2'd0;
	localparam logic [1:0] STATUS_CRC_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_TOO_SHORT    = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       frame_done;
		logic [1:0] status;
		len_t       payload_length;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* design/fc_rx_if.sv */
interface fc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source(output valid, output data_byte, output end_of_buffer, input ready);
	modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface

/* design/fc_tx_if.sv */
interface fc_tx_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic        frame_done;
	logic [1:0]  status;
	logic [15:0] payload_length;

	modport source(output valid, output payload_byte, output payload_valid,
		output frame_done, output status, output payload_length, input ready);
	modport sink(input valid, input payload_byte, input payload_valid,
		input frame_done, input status, input payload_length, output ready);
endinterface

/* design/fc_in_reg.sv */
module fc_in_reg (
	input  logic             clk,
	input  logic             arst_n,
	fc_rx_if.sink            rx,
	input  logic             take,
	output logic             valid_s1,
	output fc_pkg::rx_item_t item_s1
);
	import fc_pkg::*;

	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			item_s1.data_byte     <= rx.data_byte;
			item_s1.end_of_buffer <= rx.end_of_buffer;
		end
	end

endmodule

/* design/fc_parser.sv */
module fc_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  fc_pkg::rx_item_t item_s1,
	input  logic             out_free,
	output logic             take,
	output logic             load,
	output fc_pkg::result_t  res
);
	import fc_pkg::*;

	pos_t        pos_q;
	logic [31:0] crc_q;
	logic [31:0] exp_q;
	len_t        hlen_q;
	logic        fin_q;

	logic        is_crc, pv, complete, done, eob, has_result;
	logic [7:0]  b;
	logic [31:0] crc_next, exp_next;
	len_t        hlen_next;

	assign b   = item_s1.data_byte;
	assign eob = item_s1.end_of_buffer;

	always_comb begin
		is_crc    = (pos_q >= POS_CRC_LO) && (pos_q < HDR_BYTES);
		pv        = pos_q >= HDR_BYTES;
		crc_next  = crc_byte(crc_q, is_crc ? 8'd0 : b);
		hlen_next = hlen_q;
		if (pos_q == POS_LEN_LO) begin
			hlen_next[7:0] = b;
		end else if (pos_q == POS_LEN_HI) begin
			hlen_next[15:8] = b;
		end
		// each CRC byte lands in a lane that is still zero
		exp_next = exp_q;
		if (is_crc) begin
			exp_next[{pos_q[1:0], 3'b000} +: 8] = b;
		end
		complete   = (pos_q >= POS_HDR_LAST) && (pos_q == POS_HDR_LAST + {1'b0, hlen_next});
		done       = complete || eob;
		has_result = !fin_q && (pv || done);
	end

	always_comb begin
		res.payload_byte   = pv ? b : 8'd0;
		res.payload_valid  = pv;
		res.frame_done     = done;
		if (!done) begin
			res.status = STATUS_OK;
		end else if (complete) begin
			res.status = ((~crc_next) != exp_next) ? STATUS_CRC_MISMATCH : STATUS_OK;
		end else begin
			res.status = STATUS_TOO_SHORT;
		end
		res.payload_length = (done && pos_q >= POS_LEN_HI) ? hlen_next : '0;
	end

	assign take = valid_s1 && (out_free || !has_result);
	assign load = take && has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			crc_q  <= CRC_INIT;
			exp_q  <= '0;
			hlen_q <= '0;
			fin_q  <= 1'b0;
		end else if (take) begin
			if (eob) begin
				pos_q  <= '0;
				crc_q  <= CRC_INIT;
				exp_q  <= '0;
				hlen_q <= '0;
				fin_q  <= 1'b0;
			end else if (!fin_q) begin
				pos_q  <= pos_q + pos_t'(1);
				crc_q  <= crc_next;
				exp_q  <= exp_next;
				hlen_q <= hlen_next;
				fin_q  <= complete;
			end
		end
	end

`ifndef SYNTHESIS
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		take && eob |=> pos_q == '0 && crc_q == CRC_INIT && !fin_q && exp_q == '0)
		else $error("parser did not rearm after last beat of buffer");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		take && !fin_q && !eob && res.frame_done |=> fin_q)
		else $error("frame verdict without entering trailing state");

	a_trail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q || pos_q == '0)
		else $error("left trailing state other than by rearm");

	a_quiet_trail: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> !load)
		else $error("result produced while ignoring trailing beats");
`endif

endmodule

/* design/fc_out_reg.sv */
module fc_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  fc_pkg::result_t res,
	output logic            out_free,
	fc_tx_if.source         tx
);
	import fc_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign out_free = !valid_q || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= res;
		end
	end

	assign tx.valid          = valid_q;
	assign tx.payload_byte   = res_q.payload_byte;
	assign tx.payload_valid  = res_q.payload_valid;
	assign tx.frame_done     = res_q.frame_done;
	assign tx.status         = res_q.status;
	assign tx.payload_length = res_q.payload_length;

endmodule

/* design/crc32_frame_checker.sv */
// A beat waits in the input register; its result is held in the output register.
// Throughput: one beat per cycle unless tx stalls a result; the byte-wide CRC
// update sits between the input register and the state/result registers.
// Header beats that end neither frame nor buffer, and trailing beats, give no
// result and never wait on tx.
// Reset (arst_n low, asynchronous): parser rearmed, CRC all ones, both stages empty.
module crc32_frame_checker (
	input  logic    clk,
	input  logic    arst_n,
	fc_rx_if.sink   rx,
	fc_tx_if.source tx
);
	import fc_pkg::*;

	logic     valid_s1;
	rx_item_t item_s1;
	logic     take, load, out_free;
	result_t  res;

	fc_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	fc_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.take     (take),
		.load     (load),
		.res      (res)
	);

	fc_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.out_free (out_free),
		.tx       (tx)
	);

endmodule
